// File: hw/rtl/dpbi_pkg.sv
// Package for the double power-by-integer block: constants, controller command and status types.
// Used by dpbi_fmul, dpbi_fdiv, dpbi_ctrl, dpbi_dp and the top level; no dependencies.
package dpbi_pkg;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam int unsigned ExpWidth  = 32;
  localparam int unsigned DataWidth = 64;

  typedef struct packed {
    logic load;      // capture the input item
    logic start_div; // start the reciprocal
    logic take_div;  // base <= quotient, exponent <= negated exponent
    logic start_mul; // start a multiply
    logic mul_sq;    // 1: square the base, 0: acc times base
    logic take_mul;  // write the product back
    logic shift_e;   // shift the exponent right by one
    logic finish;    // form the result register
  } dpbi_cmd_t;

  typedef struct packed {
    logic special;   // NaN base or zero exponent: no loop
    logic do_recip;  // negative exponent with nonzero base
    logic e_zero;    // exponent exhausted
    logic e_lsb;     // current exponent bit
    logic e_last;    // exponent is one: no further squaring
    logic div_done;
    logic mul_done;
  } dpbi_sts_t;

  function automatic logic is_nan(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

endpackage

// File: hw/rtl/dpbi_fmul.sv
// Binary64 multiplier with round to nearest even, one partial product a cycle.
// Depends on dpbi_pkg.
module dpbi_fmul import dpbi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         sign_q, sign_d;
  logic         spec_q, spec_d;
  logic [63:0]  spec_val_q, spec_val_d;
  logic [52:0]  ma_q, ma_d, mb_q, mb_d;
  logic signed [13:0] exp_q, exp_d;
  logic [105:0] prod_q, prod_d;
  logic [105:0] normed_q, normed_d;
  logic signed [13:0] en_q, en_d;
  logic [63:0]  p_q, p_d;

  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        za, zb, ia, ib, na, nb;
  logic [52:0] ma_raw, mb_raw;
  logic [5:0]  lza, lzb;
  logic [26:0] part_a, part_b;
  logic [53:0] part;
  logic [6:0]  nz;
  logic [105:0] normed;
  logic signed [13:0] e_n;
  logic [52:0] mant;
  logic        guard, sticky, rnd_up;
  logic [53:0] mant_r;
  logic [11:0] rsh;
  logic [105:0] den_src;
  logic signed [13:0] e_fin;

  always_comb begin
    ea = a_i[62:52]; eb = b_i[62:52];
    fa = a_i[51:0];  fb = b_i[51:0];
    za = (ea == 11'd0) && (fa == 52'd0);
    zb = (eb == 11'd0) && (fb == 52'd0);
    ia = (ea == 11'h7FF) && (fa == 52'd0);
    ib = (eb == 11'h7FF) && (fb == 52'd0);
    na = is_nan(a_i);
    nb = is_nan(b_i);
    ma_raw = {(ea != 11'd0), fa};
    mb_raw = {(eb != 11'd0), fb};
    lza = 6'd0;
    for (int i = 0; i < 53; i++) if (ma_raw[i]) lza = 6'(52 - i);
    lzb = 6'd0;
    for (int i = 0; i < 53; i++) if (mb_raw[i]) lzb = 6'(52 - i);
  end

  // Product is built from 27-bit halves of a and b, one pair of halves per cycle.
  assign part_a = cnt_q[1] ? ma_q[52:26] : {1'b0, ma_q[25:0]};
  assign part_b = cnt_q[0] ? mb_q[52:26] : {1'b0, mb_q[25:0]};
  assign part   = 54'(part_a) * 54'(part_b);

  always_comb begin
    nz = 7'd0;
    for (int i = 0; i < 106; i++) if (prod_q[i]) nz = 7'(105 - i);
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; sign_d = sign_q; spec_d = spec_q;
    spec_val_d = spec_val_q; ma_d = ma_q; mb_d = mb_q;
    exp_d = exp_q; prod_d = prod_q; p_d = p_q;
    normed_d = normed_q; en_d = en_q;
    normed = prod_q << nz;
    e_n = exp_q - 14'(nz) + 14'sd1;
    rsh = 12'd0;
    den_src = normed_q;
    e_fin = en_q;
    if (en_q < 14'sd1) begin
      rsh = (14'sd1 - en_q > 14'sd120) ? 12'd120 : 12'(14'sd1 - en_q);
      den_src = normed_q >> rsh;
      e_fin = 14'sd0;
    end
    mant   = den_src[105:53];
    guard  = den_src[52];
    sticky = (den_src[51:0] != 52'd0) || ((normed_q & ~({106{1'b1}} << rsh)) != 106'd0);
    rnd_up = guard && (sticky || mant[0]);
    mant_r = {1'b0, mant} + 54'(rnd_up);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sign_d = a_i[63] ^ b_i[63];
          spec_d = 1'b1;
          if (na || nb || (ia && zb) || (za && ib)) spec_val_d = QNAN_BITS;
          else if (ia || ib) spec_val_d = {a_i[63] ^ b_i[63], 11'h7FF, 52'd0};
          else if (za || zb) spec_val_d = {a_i[63] ^ b_i[63], 63'd0};
          else spec_d = 1'b0;
          ma_d = ma_raw << lza; mb_d = mb_raw << lzb;
          exp_d = 14'(ea == 11'd0 ? 11'd1 : ea) + 14'(eb == 11'd0 ? 11'd1 : eb)
                  - 14'sd1023 - 14'(lza) - 14'(lzb);
          prod_d = 106'd0; cnt_d = 2'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_q == 2'd0) prod_d = 106'(part);
        else if (cnt_q == 2'd3) prod_d = prod_q + (106'(part) << 52);
        else prod_d = prod_q + (106'(part) << 26);
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = S_NORM;
      end
      S_NORM: begin
        // Leading bit at 105 means value in [2,4); exponent counts that.
        normed_d = normed;
        en_d     = e_n;
        state_d  = S_RND;
      end
      S_RND: begin
        if (spec_q) p_d = spec_val_q;
        else if (mant_r[53]) begin
          if (e_fin + 14'sd1 >= 14'sd2047) p_d = {sign_q, 11'h7FF, 52'd0};
          else p_d = {sign_q, 11'(e_fin + 14'sd1), mant_r[52:1]};
        end else if (e_fin == 14'sd0) begin
          p_d = {sign_q, 10'd0, mant_r[52], mant_r[51:0]};
        end else if (e_fin >= 14'sd2047) p_d = {sign_q, 11'h7FF, 52'd0};
        else p_d = {sign_q, 11'(e_fin), mant_r[51:0]};
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d; spec_q <= spec_d; spec_val_q <= spec_val_d;
    ma_q <= ma_d; mb_q <= mb_d;
    exp_q <= exp_d; prod_q <= prod_d; p_q <= p_d;
    normed_q <= normed_d; en_q <= en_d;
  end

  assign done_o = (state_q == S_DONE);
  assign p_o    = p_q;

endmodule

// File: hw/rtl/dpbi_fdiv.sv
// Binary64 reciprocal 1/b, restoring division one quotient bit a cycle, round to nearest even.
// Depends on dpbi_pkg.
module dpbi_fdiv import dpbi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RND  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;
  localparam int unsigned QBits = 56;

  logic [1:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        sign_q, sign_d, spec_q, spec_d;
  logic [63:0] spec_val_q, spec_val_d;
  logic [53:0] rem_q, rem_d;
  logic [52:0] den_q, den_d;
  logic [QBits-1:0] quo_q, quo_d;
  logic signed [13:0] exp_q, exp_d;
  logic [63:0] q_q, q_d;

  logic [10:0] eb;
  logic [51:0] fb;
  logic [52:0] mb_raw;
  logic [5:0]  lz;
  logic [53:0] trial;
  logic [QBits-1:0] norm_q;
  logic signed [13:0] e_n, e_fin;
  logic [11:0] rsh;
  logic [QBits-1:0] src;
  logic        sticky_all, guard, sticky, rnd_up;
  logic [52:0] mant;
  logic [53:0] mant_r;

  always_comb begin
    eb = b_i[62:52]; fb = b_i[51:0];
    mb_raw = {(eb != 11'd0), fb};
    lz = 6'd0;
    for (int i = 0; i < 53; i++) if (mb_raw[i]) lz = 6'(52 - i);
  end

  assign trial = rem_q - {1'b0, den_q};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; sign_d = sign_q; spec_d = spec_q;
    spec_val_d = spec_val_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    exp_d = exp_q; q_d = q_q;
    // Quotient of 1.0 over [1,2) lies in (0.5,1]; normalise by one place at most.
    norm_q = quo_q[QBits-1] ? quo_q : (quo_q << 1);
    e_n = quo_q[QBits-1] ? exp_q : exp_q - 14'sd1;
    rsh = 12'd0; e_fin = e_n; src = norm_q;
    if (e_n < 14'sd1) begin
      rsh = (14'sd1 - e_n > 14'sd60) ? 12'd60 : 12'(14'sd1 - e_n);
      src = norm_q >> rsh; e_fin = 14'sd0;
    end
    sticky_all = (rem_q != 54'd0) || ((norm_q & ~({QBits{1'b1}} << rsh)) != '0);
    mant   = src[QBits-1:QBits-53];
    guard  = src[QBits-54];
    sticky = (src[QBits-55:0] != '0) || sticky_all;
    rnd_up = guard && (sticky || mant[0]);
    mant_r = {1'b0, mant} + 54'(rnd_up);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sign_d = b_i[63];
          spec_d = 1'b1;
          if (is_nan(b_i)) spec_val_d = QNAN_BITS;
          else if (eb == 11'h7FF) spec_val_d = {b_i[63], 63'd0};
          else if (b_i[62:0] == 63'd0) spec_val_d = {b_i[63], 11'h7FF, 52'd0};
          else spec_d = 1'b0;
          den_d = mb_raw << lz;
          rem_d = {1'b0, 1'b1, 52'd0}; // 1.0 aligned with the divisor
          exp_d = 14'sd1023 + 14'sd1023 - 14'(eb == 11'd0 ? 11'd1 : eb) + 14'(lz);
          quo_d = '0; cnt_d = 6'd0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!trial[53]) begin
          rem_d = {trial[52:0], 1'b0};
          quo_d = {quo_q[QBits-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[52:0], 1'b0};
          quo_d = {quo_q[QBits-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(QBits - 1)) state_d = S_RND;
      end
      S_RND: begin
        if (spec_q) q_d = spec_val_q;
        else if (mant_r[53]) begin
          if (e_fin + 14'sd1 >= 14'sd2047) q_d = {sign_q, 11'h7FF, 52'd0};
          else q_d = {sign_q, 11'(e_fin + 14'sd1), mant_r[52:1]};
        end else if (e_fin == 14'sd0) q_d = {sign_q, 10'd0, mant_r[52], mant_r[51:0]};
        else if (e_fin >= 14'sd2047) q_d = {sign_q, 11'h7FF, 52'd0};
        else q_d = {sign_q, 11'(e_fin), mant_r[51:0]};
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d; spec_q <= spec_d; spec_val_q <= spec_val_d;
    rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; exp_q <= exp_d; q_q <= q_d;
  end

  assign done_o = (state_q == S_DONE);
  assign q_o    = q_q;

endmodule

// File: hw/rtl/dpbi_dp.sv
// Datapath: base, accumulator and exponent registers around the shared multiplier and the divider.
// Depends on dpbi_pkg, dpbi_fmul and dpbi_fdiv.
module dpbi_dp import dpbi_pkg::*; #(
  parameter int unsigned EW = ExpWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dpbi_cmd_t     cmd_i,
  output dpbi_sts_t     sts_o,
  input  logic [63:0]   base_bits_i,
  input  logic [EW-1:0] exponent_i,
  input  logic          z2z_nan_i,
  output logic [63:0]   result_o
);

  logic [63:0]   base_q, base_d, acc_q, acc_d, res_q, res_d, in_q, in_d;
  logic [EW-1:0] e_q, e_d;
  logic          spec_q, spec_d;
  logic [63:0]   mul_p, div_q;
  logic          mul_done, div_done;
  logic          in_zero, in_nan;

  assign in_zero = (in_q[62:0] == 63'd0);
  assign in_nan  = is_nan(in_q);

  dpbi_fmul u_fmul (
    .clk_i, .rst_ni, .start_i(cmd_i.start_mul),
    .a_i(cmd_i.mul_sq ? base_q : acc_q), .b_i(base_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  dpbi_fdiv u_fdiv (
    .clk_i, .rst_ni, .start_i(cmd_i.start_div), .b_i(base_q),
    .done_o(div_done), .q_o(div_q)
  );

  always_comb begin
    base_d = base_q; acc_d = acc_q; res_d = res_q; in_d = in_q; e_d = e_q;
    spec_d = spec_q;
    if (cmd_i.load) begin
      base_d = base_bits_i; in_d = base_bits_i; e_d = exponent_i; acc_d = ONE_BITS;
      // The exponent is shifted down to zero by the loop, so the item's kind is kept here.
      spec_d = is_nan(base_bits_i) || (exponent_i == '0);
    end
    if (cmd_i.take_div) begin
      base_d = div_q; e_d = '0 - e_q;
    end
    if (cmd_i.take_mul) begin
      if (cmd_i.mul_sq) base_d = mul_p;
      else acc_d = mul_p;
    end
    if (cmd_i.shift_e) e_d = e_q >> 1;
    if (cmd_i.finish) begin
      if (in_nan) res_d = (e_q == '0) ? in_q : (in_q | QUIET_BIT);
      else if (spec_q) res_d = (in_zero && z2z_nan_i) ? QNAN_BITS : ONE_BITS;
      else res_d = is_nan(acc_q) ? QNAN_BITS : acc_q;
    end
  end

  always_comb begin
    sts_o.special  = in_nan || (e_q == '0);
    sts_o.do_recip = e_q[EW-1] && !in_zero;
    sts_o.e_zero   = (e_q == '0);
    sts_o.e_lsb    = e_q[0];
    sts_o.e_last   = (e_q == EW'(1));
    sts_o.div_done = div_done;
    sts_o.mul_done = mul_done;
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d; acc_q <= acc_d; res_q <= res_d; in_q <= in_d; e_q <= e_d;
    spec_q <= spec_d;
  end

  assign result_o = res_q;

endmodule

// File: hw/rtl/dpbi_ctrl.sv
// Controller: sequences reciprocal, multiplies and exponent shifts; owns the handshakes.
// Depends on dpbi_pkg.
module dpbi_ctrl import dpbi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dpbi_cmd_t cmd_o,
  input  dpbi_sts_t sts_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_BIT   = 4'd3;
  localparam logic [3:0] S_MULA  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQW   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o  = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
    out_valid_o = (state_q == S_OUT);
    unique case (state_q)
      S_IDLE, S_OUT: begin
        if (state_q == S_OUT && out_ready_i) state_d = S_IDLE;
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1; state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.special) state_d = S_FIN;
        else if (sts_i.do_recip) begin
          cmd_o.start_div = 1'b1; state_d = S_DIV;
        end else state_d = S_BIT;
      end
      S_DIV: if (sts_i.div_done) begin
        cmd_o.take_div = 1'b1; state_d = S_BIT;
      end
      S_BIT: begin
        if (sts_i.e_zero) state_d = S_FIN;
        else if (sts_i.e_lsb) begin
          cmd_o.start_mul = 1'b1; state_d = S_MULA;
        end else begin
          state_d = S_SQ;
        end
      end
      S_MULA: if (sts_i.mul_done) begin
        cmd_o.take_mul = 1'b1; state_d = S_SQ;
      end
      S_SQ: begin
        if (sts_i.e_last) begin
          cmd_o.shift_e = 1'b1; state_d = S_FIN;
        end else begin
          cmd_o.start_mul = 1'b1; cmd_o.mul_sq = 1'b1; state_d = S_SQW;
        end
      end
      S_SQW: begin
        cmd_o.mul_sq = 1'b1;
        if (sts_i.mul_done) begin
          cmd_o.take_mul = 1'b1; cmd_o.shift_e = 1'b1; state_d = S_BIT;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1; state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/double_power_by_integer.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata[63:0] base_bits, tdata[95:64] exponent
// m_axis   | out       | tdata[63:0] result_bits
// cfg      | in        | cfg_data_i[0] zero_to_zero_nan
// One item at a time. The result follows a loop over the exponent bits: for each set bit
// the accumulator is multiplied by the base, and for each bit below the top one the base
// is squared. A negative exponent with a nonzero base first takes the reciprocal of the
// base. The multiplier forms four partial products, then normalises and rounds.
// Reset is asynchronous and clears control state and the zero-to-zero setting only. A held
// result does not block acceptance of the next item once it is taken in the same cycle.
module double_power_by_integer import dpbi_pkg::*; #(
  parameter int unsigned EW = ExpWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // base_bits [63:0], exponent [95:64]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // result_bits [63:0]
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);

  dpbi_cmd_t cmd;
  dpbi_sts_t sts;
  logic      z2z_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) z2z_q <= 1'b0;
    else if (cfg_valid_i) z2z_q <= cfg_data_i;
  end

  dpbi_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  dpbi_dp #(.EW(EW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .base_bits_i(s_axis_tdata[63:0]), .exponent_i(s_axis_tdata[64 +: EW]),
    .z2z_nan_i(z2z_q), .result_o(m_axis_tdata)
  );

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> s_axis_tvalid && s_axis_tready) else $error("load without handshake");
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.start_mul && cmd.start_div)) else $error("two units started together");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

endmodule

// File: bench/double_power_by_integer_tb.sv
// Self-checking bench for double_power_by_integer: directed and random base/exponent
// items under several idling patterns, checked against a square-and-multiply predictor.
// Depends on dpbi_pkg and the double_power_by_integer RTL only.
`timescale 1ns / 100ps

module double_power_by_integer_tb;
  import dpbi_pkg::*;

  class power_scoreboard;
    logic [63:0] pending_powers[$];
    bit          zero_pow_zero_nan;
    int          mismatches;
    int          checked;

    function bit nan_bits(logic [63:0] b);
      return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    // Square-and-multiply in host binary64, rounded to nearest even.
    function logic [63:0] predict_power(logic [63:0] base_bits, logic [31:0] expo);
      real         sq;
      real         acc;
      logic [31:0] e;
      logic [63:0] rb;
      bit          zero_base;
      zero_base = (base_bits[62:0] == 63'd0);
      e = expo;
      if (e == 32'd0) begin
        if (nan_bits(base_bits)) return base_bits;
        if (zero_base && zero_pow_zero_nan) return QNAN_BITS;
        return ONE_BITS;
      end
      if (nan_bits(base_bits)) return base_bits | QUIET_BIT;
      sq  = $bitstoreal(base_bits);
      acc = 1.0;
      // A zero base has no reciprocal: the raw pattern drives the loop.
      if (e[31] && !zero_base) begin
        sq = 1.0 / sq;
        e  = 32'd0 - e;
      end
      while (e != 32'd0) begin
        if (e[0]) acc = acc * sq;
        e = e >> 1;
        if (e != 32'd0) sq = sq * sq;
      end
      rb = $realtobits(acc);
      if (nan_bits(rb)) rb = QNAN_BITS;
      return rb;
    endfunction

    function void note_operand(logic [63:0] base_bits, logic [31:0] expo);
      pending_powers.push_back(predict_power(base_bits, expo));
    endfunction

    function void check_result(logic [63:0] actual);
      logic [63:0] want;
      if (pending_powers.size() == 0) begin
        $error("result_bits: unexpected item, actual %h", actual);
        mismatches++;
        return;
      end
      want = pending_powers.pop_front();
      checked++;
      if (want !== actual) begin
        $error("result_bits: expected %h, actual %h", want, actual);
        mismatches++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // base_bits [63:0], exponent [95:64]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // result_bits [63:0]
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  power_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  int unsigned operands_sent;

  double_power_by_integer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both handshakes are sampled at the edge, before the block updates anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_operand(s_axis_tdata[63:0], s_axis_tdata[95:64]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Watchdog expired with %0d items outstanding.", sb.pending_powers.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_operand(input logic [63:0] base_bits, input logic [31:0] expo);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {expo, base_bits};
    do @(posedge clk_i); while (!s_axis_tready);
    operands_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_powers.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_zero_pow_mode(input bit nan_mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= nan_mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.zero_pow_zero_nan = nan_mode;
  endtask

  function automatic logic [63:0] random_base();
    int unsigned pick;
    logic [63:0] b;
    pick = $urandom_range(99);
    b = {$urandom, $urandom};
    if (pick < 20) return b;
    if (pick < 70) begin
      // Near unity, so that long exponents stay in range for a while.
      b[62:52] = 11'(32'd1019 + $urandom_range(8));
      return b;
    end
    if (pick < 85) begin
      case ($urandom_range(6))
        0: return {b[63], 63'd0};
        1: return {b[63], 11'h7FF, 52'd0};
        2: return {b[63], 11'h7FF, b[51:0] | 52'd1};
        3: return {b[63], 11'd0, b[51:0]};
        4: return {b[63], 11'h7FE, b[51:0]};
        5: return {b[63], 11'd1, b[51:0]};
        default: return {b[63], 11'd1023, 52'd0};
      endcase
    end
    // Small integers and powers of two give exact results.
    return $realtobits($itor($urandom_range(1, 9)) * ($urandom_range(1) ? 1.0 : -1.0));
  endfunction

  function automatic logic [31:0] random_exponent();
    int unsigned pick;
    logic [31:0] e;
    pick = $urandom_range(99);
    if (pick < 60) e = $urandom_range(40);
    else if (pick < 75) e = $urandom_range(1200);
    else if (pick < 88) return $urandom;
    else begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'd0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom_range(1) ? 32'd0 - e : e;
  endfunction

  initial begin
    logic [63:0] edge_bases[12];
    logic [31:0] edge_exps[7];
    int unsigned idle_set[4][2];

    sb = new();
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    operands_sent  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    edge_bases = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                   64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'hFFF4_5678_9ABC_DEF0,
                   ONE_BITS, 64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000,
                   64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    edge_exps = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3,
                  32'hFFFF_FFFD};

    // Directed part: every edge base once with a cycling exponent, then zero cases.
    write_zero_pow_mode(1'b0);
    foreach (edge_bases[i]) send_operand(edge_bases[i], edge_exps[i % 7]);
    foreach (edge_exps[j]) send_operand(64'h0, edge_exps[j]);
    send_operand(64'h8000_0000_0000_0000, 32'd0);
    // Sender holds off until every result is back.
    drain_results();
    write_zero_pow_mode(1'b1);
    send_operand(64'h0, 32'd0);
    send_operand(64'h8000_0000_0000_0000, 32'd0);
    send_operand(64'h7FF8_0000_0000_0000, 32'd0);
    send_operand(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    drain_results();

    idle_set = '{'{0, 0}, '{70, 0}, '{0, 70}, '{37, 37}};
    for (int ph = 0; ph < 4; ph++) begin
      write_zero_pow_mode(ph[0]);
      send_idle_pct  = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      repeat (362) send_operand(random_base(), random_exponent());
      drain_results();
    end

    $display("Sent %0d items over four idling patterns, %0d results checked,",
             operands_sent, sb.checked);
    $display("with zero-to-zero mode toggled between phases.");
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dpbi_pkg.sv
hw/rtl/dpbi_fmul.sv
hw/rtl/dpbi_fdiv.sv
hw/rtl/dpbi_dp.sv
hw/rtl/dpbi_ctrl.sv
hw/rtl/double_power_by_integer.sv
bench/double_power_by_integer_tb.sv
